[rtl/event_sequence_trigger_assert.svh]
// ----------------------------------------------------------------------------
// Event sequence trigger assertion macros
// Concurrent assertion wrappers; ASSERT_OFF compiles them out.
// ----------------------------------------------------------------------------
`ifndef EVENT_SEQUENCE_TRIGGER_ASSERT_SVH
`define EVENT_SEQUENCE_TRIGGER_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define ESQ_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("event_sequence_trigger: assertion failed");
// Next-cycle implication
`define ESQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("event_sequence_trigger: assertion failed");
`else
`define ESQ_ASSERT(label, clk, rst, ante, cons)
`define ESQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/esq_pkg.sv]
// ----------------------------------------------------------------------------
// esq_pkg
// Field widths, request codes and shared types of the event sequence trigger.
// ----------------------------------------------------------------------------
`default_nettype none

package esq_pkg;

  // Payload field widths
  localparam int REQ_TYPE_W    = 3;
  localparam int EVENT_ID_W    = 8;
  localparam int STRAT_SEL_W   = 3;
  localparam int PATTERN_POS_W = 4;
  localparam int WRITE_VALUE_W = 32;
  localparam int RSP_MASK_W    = 8;
  localparam int RSP_COUNT_W   = 4;

  // Request codes
  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_EVENT   = 3'd0,
    REQ_TICK    = 3'd1,
    REQ_PATTERN = 3'd2,
    REQ_LENGTH  = 3'd3,
    REQ_DELAY   = 3'd4
  } req_code_t;

  // Control for the history cell chain
  typedef struct packed {
    logic push;    // shift in a new event, newest at cell 0
    logic rotate;  // rotate toward cell 0, last cell takes cell 0
  } hist_ctl_t;

endpackage

`default_nettype wire

[rtl/esq_req_if.sv]
// ----------------------------------------------------------------------------
// esq_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface esq_req_if;
  import esq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_TYPE_W-1:0]    req_type;
  logic [EVENT_ID_W-1:0]    event_id;
  logic [STRAT_SEL_W-1:0]   strategy_sel;
  logic [PATTERN_POS_W-1:0] pattern_pos;
  logic [WRITE_VALUE_W-1:0] write_value;

  modport source (
    output valid, req_type, event_id, strategy_sel, pattern_pos, write_value,
    input  ready
  );

  modport sink (
    input  valid, req_type, event_id, strategy_sel, pattern_pos, write_value,
    output ready
  );
endinterface

`default_nettype wire

[rtl/esq_rsp_if.sv]
// ----------------------------------------------------------------------------
// esq_rsp_if
// Result channel: valid/ready handshake with fire mask and pulse count.
// ----------------------------------------------------------------------------
`default_nettype none

interface esq_rsp_if;
  import esq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [RSP_MASK_W-1:0]  fire_mask;
  logic [RSP_COUNT_W-1:0] pulse_count;

  modport source (
    output valid, fire_mask, pulse_count,
    input  ready
  );

  modport sink (
    input  valid, fire_mask, pulse_count,
    output ready
  );
endinterface

`default_nettype wire

[rtl/esq_hist_cell.sv]
// ----------------------------------------------------------------------------
// esq_hist_cell
// One history slot; shifts from its newer-side neighbor on a push and from
// its older-side neighbor on a rotate.
// ----------------------------------------------------------------------------
`default_nettype none

module esq_hist_cell (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire esq_pkg::hist_ctl_t             ctl,
  input  wire logic [esq_pkg::EVENT_ID_W-1:0] push_in,
  input  wire logic [esq_pkg::EVENT_ID_W-1:0] rot_in,
  output logic      [esq_pkg::EVENT_ID_W-1:0] data
);
  import esq_pkg::*;

  // Hold, shift in, or rotate
  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else if (ctl.push) begin
      data <= push_in;
    end else if (ctl.rotate) begin
      data <= rot_in;
    end
  end
endmodule

`default_nettype wire

[rtl/event_sequence_trigger.sv]
// Event request: each strategy in turn rotates the history chain once past one
//   shared comparator.
// One request is in flight at a time; a finished result waits in the output
//   register meanwhile.
// Reset: synchronous; a clearing pass zeroes the pattern memory, with req.ready
//   low until it ends.
// ----------------------------------------------------------------------------
// event_sequence_trigger
// Matches recent event identifiers against programmable patterns and fires
// pulses at once or after a tick countdown.
// ----------------------------------------------------------------------------
`default_nettype none

`include "event_sequence_trigger_assert.svh"

module event_sequence_trigger #(
  parameter int HISTORY_DEPTH  = 16,
  parameter int STRATEGY_COUNT = 8
) (
  input wire logic clk,
  input wire logic rst,
  esq_req_if.sink  req,
  esq_rsp_if.source rsp
);
  import esq_pkg::*;

  localparam int SW    = (STRATEGY_COUNT > 1) ? $clog2(STRATEGY_COUNT) : 1;
  localparam int HIW   = $clog2(HISTORY_DEPTH);
  localparam int LW    = $clog2(HISTORY_DEPTH + 1);
  localparam int DEPTH = STRATEGY_COUNT * HISTORY_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MATCH = 5'b00100,
    ST_TICK  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  // Strategy tables
  logic [LW-1:0]            pat_len   [STRATEGY_COUNT];
  logic [WRITE_VALUE_W-1:0] delay     [STRATEGY_COUNT];
  logic [WRITE_VALUE_W-1:0] countdown [STRATEGY_COUNT];

  // Pattern memory
  logic [EVENT_ID_W-1:0] pat_mem [DEPTH];
  logic [EVENT_ID_W-1:0] mem_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [EVENT_ID_W-1:0] mem_wd;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         clr_addr;

  // Sequencer
  logic [SW-1:0]         sidx;
  logic [LW-1:0]         step;
  logic                  ok;
  logic                  cmp_en;
  logic [EVENT_ID_W-1:0] cmp_hist;
  logic [RSP_MASK_W-1:0] mask;
  logic [RSP_COUNT_W-1:0] count;
  logic                  out_valid;
  logic [RSP_MASK_W-1:0] out_mask;
  logic [RSP_COUNT_W-1:0] out_count;

  // History chain
  logic [EVENT_ID_W-1:0] hist [HISTORY_DEPTH];
  hist_ctl_t             hist_ctl;

  logic                  req_xfer;
  logic                  sel_ok;
  logic [SW-1:0]         sel_idx;
  logic [LW-1:0]         cur_len;
  logic                  step_last;
  logic                  strat_last;
  logic                  cmp_en_next;
  logic [LW-1:0]         col_full;
  logic [HIW-1:0]        col;
  logic                  pass;
  logic                  hit;
  logic [WRITE_VALUE_W-1:0] cd_cur;
  logic                  fire;
  logic [RSP_MASK_W-1:0] fire_bit;
  logic                  out_load;

  assign req.ready       = (state == ST_IDLE);
  assign req_xfer        = req.valid && req.ready;
  assign sel_ok          = int'(req.strategy_sel) < STRATEGY_COUNT;
  assign sel_idx         = SW'(req.strategy_sel);
  assign cur_len         = pat_len[sidx];
  assign step_last       = (step == LW'(HISTORY_DEPTH));
  assign strat_last      = (sidx == SW'(STRATEGY_COUNT - 1));
  assign cd_cur          = countdown[sidx];

  // Pattern byte for the current history offset, newest against the last byte
  assign cmp_en_next     = (step < cur_len);
  assign col_full        = cur_len - LW'(1) - step;
  assign col             = cmp_en_next ? col_full[HIW-1:0] : '0;
  assign rd_addr         = AW'(int'(sidx) * HISTORY_DEPTH + int'(col));

  // Compare the byte read last cycle with the history byte taken with it
  assign pass = !cmp_en ||
                ((cmp_hist != '0) && ((mem_q == '0) || (mem_q == cmp_hist)));
  assign hit  = ok && pass;

  // Pulse for the current strategy
  assign fire = ((state == ST_TICK) && (cd_cur == WRITE_VALUE_W'(1))) ||
                ((state == ST_MATCH) && step_last && hit && (delay[sidx] == '0));
  assign fire_bit = (fire && (int'(sidx) < RSP_MASK_W)) ?
                    (RSP_MASK_W'(1) << sidx) : '0;

  assign out_load = (state == ST_DONE) && (!out_valid || rsp.ready);

  // Drive the history chain
  assign hist_ctl.push   = req_xfer && (req.req_type == REQ_EVENT);
  assign hist_ctl.rotate = (state == ST_MATCH) && !step_last;

  for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_hist
    logic [EVENT_ID_W-1:0] push_src;
    if (k == 0) begin : g_head
      assign push_src = req.event_id;
    end else begin : g_body
      assign push_src = hist[k-1];
    end
    esq_hist_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (hist_ctl),
      .push_in (push_src),
      .rot_in  (hist[(k + 1) % HISTORY_DEPTH]),
      .data    (hist[k])
    );
  end

  // Memory write port: clearing pass or pattern byte write
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr;
    mem_wd = '0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (req_xfer && (req.req_type == REQ_PATTERN) && sel_ok &&
                 (int'(req.pattern_pos) < HISTORY_DEPTH)) begin
      mem_we = 1'b1;
      mem_wa = AW'(int'(req.strategy_sel) * HISTORY_DEPTH + int'(req.pattern_pos));
      mem_wd = req.write_value[EVENT_ID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pat_mem[mem_wa] <= mem_wd;
    end
    mem_q <= pat_mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_xfer) begin
          unique case (req.req_type)
            REQ_EVENT: state_next = ST_MATCH;
            REQ_TICK:  state_next = ST_TICK;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_MATCH: begin
        if (step_last && strat_last) state_next = ST_DONE;
      end
      ST_TICK: begin
        if (strat_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Sequencer, tables and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      sidx      <= '0;
      step      <= '0;
      ok        <= 1'b0;
      cmp_en    <= 1'b0;
      mask      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      for (int s = 0; s < STRATEGY_COUNT; s++) begin
        pat_len[s]   <= '0;
        delay[s]     <= '0;
        countdown[s] <= '0;
      end
    end else begin
      state <= state_next;

      // Advance the clearing pass
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);

      // Start a request; writes take effect here
      if (req_xfer) begin
        sidx  <= '0;
        step  <= '0;
        mask  <= '0;
        count <= '0;
        case (req.req_type)
          REQ_LENGTH: begin
            if (sel_ok) begin
              pat_len[sel_idx] <= (req.write_value > WRITE_VALUE_W'(HISTORY_DEPTH)) ?
                                  LW'(HISTORY_DEPTH) : LW'(req.write_value);
            end
          end
          REQ_DELAY: begin
            if (sel_ok) begin
              delay[sel_idx]     <= req.write_value;
              countdown[sel_idx] <= '0;
            end
          end
          default: ;
        endcase
      end

      // Walk the history of one strategy at a time
      if (state == ST_MATCH) begin
        cmp_hist <= hist[0];
        if (step_last) begin
          cmp_en <= 1'b0;
          step   <= '0;
          if (!strat_last) sidx <= sidx + SW'(1);
          if (hit && (delay[sidx] != '0)) countdown[sidx] <= delay[sidx];
        end else begin
          cmp_en <= cmp_en_next;
          step   <= step + LW'(1);
          ok     <= (step == '0) ? (cur_len != '0) : (ok && pass);
        end
      end

      // Decrement one countdown per cycle
      if (state == ST_TICK) begin
        if (cd_cur != '0) countdown[sidx] <= cd_cur - WRITE_VALUE_W'(1);
        if (!strat_last) sidx <= sidx + SW'(1);
      end

      // Accumulate pulses
      if (fire) begin
        mask <= mask | fire_bit;
        if (count != '1) count <= count + RSP_COUNT_W'(1);
      end

      // Output register
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mask  <= mask;
      out_count <= count;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.fire_mask   = out_mask;
  assign rsp.pulse_count = out_count;

  // Checks
  `ESQ_ASSERT_NEXT(a_event_starts_match, clk, rst, req_xfer && (req.req_type == REQ_EVENT), state == ST_MATCH)
  `ESQ_ASSERT(a_mask_agrees_count, clk, rst, rsp.valid && (STRATEGY_COUNT <= RSP_MASK_W), $countones(rsp.fire_mask) == int'(rsp.pulse_count))
  `ESQ_ASSERT(a_result_from_done, clk, rst, $rose(rsp.valid), $past(state) == ST_DONE)
endmodule

`default_nettype wire
